// ===== src/strng_pkg.sv =====
// ----------------------------------------------------------------------------
// strng_pkg - shared types and constants of the shuffled triple-LCG generator
// Generator constants, fixed-point reciprocals, control enums and the structs
// that travel between the top level and its reduction and divider units.
// ----------------------------------------------------------------------------
package strng_pkg;

    // Default shuffle table depth (legal range 2..128)
    localparam int TABLE_SIZE_DEF = 97;

    // Generator lanes
    localparam int LANES        = 3;
    localparam int LANE_MAJOR   = 0;
    localparam int LANE_MINOR   = 1;
    localparam int LANE_SELECT  = 2;

    localparam int GEN_W = 18;
    localparam int RAW_W = 33;

    localparam logic [17:0] MOD_MAJOR  = 18'd259200;
    localparam logic [17:0] MOD_MINOR  = 18'd134456;
    localparam logic [17:0] MOD_SELECT = 18'd243000;
    localparam logic [15:0] INC_MAJOR  = 16'd54773;

    localparam logic [13:0] LANE_MUL [LANES] = '{14'd7141, 14'd8121, 14'd4561};
    localparam logic [15:0] LANE_INC [LANES] = '{16'd54773, 16'd28411, 16'd51349};
    localparam logic [17:0] LANE_MOD [LANES] = '{MOD_MAJOR, MOD_MINOR, MOD_SELECT};

    // floor(2^33 / m): the quotient estimate is low by at most one
    localparam int RECIP_SHIFT = 33;
    localparam logic [15:0] LANE_RECIP [LANES] = '{
        16'((64'd1 << RECIP_SHIFT) / 64'(MOD_MAJOR)),
        16'((64'd1 << RECIP_SHIFT) / 64'(MOD_MINOR)),
        16'((64'd1 << RECIP_SHIFT) / 64'(MOD_SELECT))
    };

    // Bias that makes (INC_MAJOR - seed) non-negative without changing its residue
    localparam logic [33:0] SEED_BIAS = 34'(64'(INC_MAJOR) +
        64'(MOD_MAJOR) * ((64'd1 << 31) / 64'(MOD_MAJOR) + 64'd1));

    // ceil(2^43 / 243000): exact floor division of TABLE_SIZE * select
    localparam int SLOT_SHIFT = 43;
    localparam logic [25:0] SLOT_RECIP = 26'(((64'd1 << SLOT_SHIFT) +
        64'(MOD_SELECT) - 64'd1) / 64'(MOD_SELECT));

    // Fraction: 134456 = 8*16807 and 259200 = 128*2025, so the quotient splits
    // into floor(minor*2^21/16807) and then a divide by 2025 after a shift
    localparam int FRAC_W = 24;
    localparam logic [14:0] FRAC_DIV_A   = 15'd16807;
    localparam logic [10:0] FRAC_DIV_B   = 11'd2025;
    localparam int          FRAC_SHIFT_A = 39;
    localparam int          FRAC_SHIFT_B = 35;
    // floor(2^shift / d): each estimate is low by at most one
    localparam logic [24:0] FRAC_RECIP_A =
        25'((64'd1 << FRAC_SHIFT_A) / 64'(FRAC_DIV_A));
    localparam logic [24:0] FRAC_RECIP_B =
        25'((64'd1 << FRAC_SHIFT_B) / 64'(FRAC_DIV_B));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_READ,
        ST_WRITE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PASS_SEED,
        PASS_MIX1,
        PASS_MIX2,
        PASS_FILL,
        PASS_DRAW
    } pass_t;

    typedef struct packed {
        logic                 use_raw;
        logic [RAW_W-1:0]     raw;
        logic [GEN_W-1:0]     x;
    } lane_op_t;

    typedef struct packed {
        logic                  go;
        lane_op_t [LANES-1:0]  op;
    } lcg_req_t;

    typedef struct packed {
        logic                        done;
        logic [LANES-1:0][GEN_W-1:0] val;
    } lcg_rsp_t;

    typedef struct packed {
        logic             start;
        logic [GEN_W-1:0] major;
        logic [GEN_W-1:0] minor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] fraction;
    } div_rsp_t;

endpackage

// ===== src/strng_lcg3.sv =====
// ----------------------------------------------------------------------------
// strng_lcg3 - three-lane modular step unit
// Each lane forms x*a+c (or takes a raw operand) and reduces it modulo its
// lane constant through a reciprocal estimate and one correction, in four
// registered stages.
// ----------------------------------------------------------------------------
module strng_lcg3 (
    input  logic                aclk,
    input  logic                aresetn,
    input  strng_pkg::lcg_req_t lcg_req,
    output strng_pkg::lcg_rsp_t lcg_rsp
);
    import strng_pkg::*;

    logic [3:0]       vld_reg;
    logic [RAW_W-1:0] p_reg  [LANES];
    logic [RAW_W-1:0] p2_reg [LANES];
    logic [15:0]      q_reg  [LANES];
    logic [18:0]      d_reg  [LANES];
    logic [GEN_W-1:0] r_reg  [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], lcg_req.go};
        end
    end

    always_ff @(posedge aclk) begin
        logic [31:0] lin;
        logic [48:0] qprod;
        logic [33:0] diff;
        for (int i = 0; i < LANES; i++) begin
            lin = 32'(lcg_req.op[i].x) * 32'(LANE_MUL[i]) + 32'(LANE_INC[i]);
            p_reg[i] <= lcg_req.op[i].use_raw ? lcg_req.op[i].raw : RAW_W'(lin);

            qprod = 49'(p_reg[i]) * 49'(LANE_RECIP[i]);
            q_reg[i]  <= qprod[48:RECIP_SHIFT];
            p2_reg[i] <= p_reg[i];

            // estimate is at most one low: remainder stays below twice the modulus
            diff = 34'(p2_reg[i]) - 34'(q_reg[i]) * 34'(LANE_MOD[i]);
            d_reg[i] <= diff[18:0];

            r_reg[i] <= (d_reg[i] >= 19'(LANE_MOD[i])) ?
                        GEN_W'(d_reg[i] - 19'(LANE_MOD[i])) : d_reg[i][GEN_W-1:0];
        end
    end

    always_comb begin
        lcg_rsp.done = vld_reg[3];
        for (int i = 0; i < LANES; i++) begin
            lcg_rsp.val[i] = r_reg[i];
        end
    end

endmodule

// ===== src/strng_frac_div.sv =====
// ----------------------------------------------------------------------------
// strng_frac_div - fixed-point fraction pipeline
// Gives floor((major*134456+minor) * 2^24 / (259200*134456)) in six registered
// stages: a reciprocal estimate of minor*2^21/16807 with one correction, then
// a reciprocal estimate of that sum divided by 2025 with one correction.
// ----------------------------------------------------------------------------
module strng_frac_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  strng_pkg::div_req_t div_req,
    output strng_pkg::div_rsp_t div_rsp
);
    import strng_pkg::*;

    logic [5:0]        vld_reg;
    logic [41:0]       pa_reg;
    logic [GEN_W-1:0]  maj1_reg, maj2_reg, maj3_reg;
    logic [FRAC_W-1:0] q1_reg;
    logic [FRAC_W-1:0] f1_reg;
    logic [42:0]       ga_reg;
    logic [41:0]       gb_reg;
    logic [11:0]       ulo_reg, ulo2_reg;
    logic [FRAC_W-1:0] q2_reg;
    logic [FRAC_W-1:0] frac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[4:0], div_req.start};
        end
    end

    always_ff @(posedge aclk) begin
        logic [15:0] rem1;
        logic [42:0] sum;
        logic [11:0] rem2;
        // minor*R_A < 2^42, and its top bits past shift 18 are the estimate
        pa_reg   <= 42'(div_req.minor) * 42'(FRAC_RECIP_A);
        maj1_reg <= div_req.major;

        q1_reg   <= pa_reg[41:18];
        maj2_reg <= maj1_reg;

        // minor*2^21 has zero low bits, so the remainder is the negated product
        rem1     = 16'(32'd0 - 32'(q1_reg[15:0]) * 32'(FRAC_DIV_A));
        f1_reg   <= q1_reg + FRAC_W'(rem1 >= 16'(FRAC_DIV_A));
        maj3_reg <= maj2_reg;

        // u = major*2^17 + f1[23:7]
        ga_reg  <= 43'(maj3_reg) * 43'(FRAC_RECIP_B);
        gb_reg  <= 42'(f1_reg[23:7]) * 42'(FRAC_RECIP_B);
        ulo_reg <= f1_reg[18:7];

        sum      = ga_reg + 43'(gb_reg[41:17]);
        q2_reg   <= sum[41:18];
        ulo2_reg <= ulo_reg;

        rem2 = 12'(24'(ulo2_reg) - 24'(q2_reg[11:0]) * 24'(FRAC_DIV_B));
        if (vld_reg[4]) begin
            frac_reg <= q2_reg + FRAC_W'(rem2 >= 12'(FRAC_DIV_B));
        end
    end

    assign div_rsp.done     = vld_reg[5];
    assign div_rsp.fraction = frac_reg;

endmodule

// ===== src/shuffled_triple_lcg_uniform_rng_unit.sv =====
// ----------------------------------------------------------------------------
// shuffled_triple_lcg_uniform_rng_unit - shuffled three-LCG uniform source
// Each request item on the s_ channel yields one deviate item on the m_
// channel: the drawn shuffle-table pair and its Q0.24 fraction.
//
// An item on s_tdata carries a signed seed. A negative seed, or the first
// item after reset, reseeds the three generators and refills the whole
// table before the draw; other seeds are ignored.
// A normal draw passes from the accepting edge through the issue state, the
// four-stage modular reduction unit, one table read, one write-back, the
// fraction pipeline and one output load before m_tvalid rises; the next
// item is taken once the block is back in idle. A reseed adds one reduction
// pass per table slot plus three setup passes.
// One item is in work at a time; s_tready is high whenever the block is
// idle, also while a result still waits in the output register.
// When the receiver stalls, the result holds on m_tdata and the next result
// waits until it is taken. Reset clears the generators and the seeded flag;
// the table is unwritten until the first item fills it.
// ----------------------------------------------------------------------------
module shuffled_triple_lcg_uniform_rng_unit #(
    parameter int TABLE_SIZE = strng_pkg::TABLE_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // seed[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // major_part[17:0], minor_part[35:18],
                                   // fraction[59:36], zero[63:60]
);
    import strng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int SLOT_PROD_W = GEN_W + 33;
    localparam logic [32:0] SLOT_MULT = 33'(TABLE_SIZE) * 33'(SLOT_RECIP);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;

    logic [GEN_W-1:0] gen_major_reg, gen_minor_reg, gen_select_reg;
    logic             seeded_reg;
    logic [IDX_W-1:0] fill_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [31:0]      seed_reg;
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;

    logic [2*GEN_W-1:0] mem [TABLE_SIZE];
    logic [2*GEN_W-1:0] rd_data_reg;
    logic               mem_re, mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [2*GEN_W-1:0] mem_wdata;

    logic     lcg_go, div_start, out_load, accept;
    lcg_req_t lcg_req;
    lcg_rsp_t lcg_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [RAW_W-1:0]       seed_diff;
    logic [SLOT_PROD_W-1:0] slot_prod;
    logic [7:0]             slot_full;
    logic [IDX_W-1:0]       slot_calc;

    assign accept = s_tvalid && s_tready;

    strng_lcg3 u_lcg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .lcg_req (lcg_req),
        .lcg_rsp (lcg_rsp)
    );

    strng_frac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Lane operands per pass; the biased difference always fits RAW_W bits
    assign seed_diff = RAW_W'(SEED_BIAS - {{2{seed_reg[31]}}, seed_reg});

    always_comb begin
        lcg_req.go = lcg_go;
        lcg_req.op[LANE_MAJOR].use_raw  = (pass_reg == PASS_SEED);
        lcg_req.op[LANE_MAJOR].raw      = seed_diff;
        lcg_req.op[LANE_MAJOR].x        = gen_major_reg;
        lcg_req.op[LANE_MINOR].use_raw  = (pass_reg == PASS_MIX2);
        lcg_req.op[LANE_MINOR].raw      = RAW_W'(gen_major_reg);
        lcg_req.op[LANE_MINOR].x        = gen_minor_reg;
        lcg_req.op[LANE_SELECT].use_raw = (pass_reg == PASS_FILL);
        lcg_req.op[LANE_SELECT].raw     = RAW_W'(gen_major_reg);
        lcg_req.op[LANE_SELECT].x       = gen_select_reg;
    end

    // Slot = floor(TABLE_SIZE * select / 243000) by exact reciprocal
    always_comb begin
        slot_prod = SLOT_PROD_W'(lcg_rsp.val[LANE_SELECT]) * SLOT_PROD_W'(SLOT_MULT);
        slot_full = 8'(slot_prod[SLOT_PROD_W-1:SLOT_SHIFT]);
        slot_calc = (slot_full >= 8'(TABLE_SIZE)) ? LAST_IDX : slot_full[IDX_W-1:0];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ISSUE;
                    pass_next  = (s_tdata[31] || !seeded_reg) ? PASS_SEED : PASS_DRAW;
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (lcg_rsp.done) begin
                    state_next = ST_ISSUE;
                    case (pass_reg)
                        PASS_SEED: pass_next = PASS_MIX1;
                        PASS_MIX1: pass_next = PASS_MIX2;
                        PASS_MIX2: pass_next = PASS_FILL;
                        PASS_FILL: pass_next = (fill_reg == LAST_IDX) ? PASS_DRAW : PASS_FILL;
                        PASS_DRAW: state_next = ST_READ;
                        default:   pass_next = PASS_DRAW;
                    endcase
                end
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready  = 1'b0;
        lcg_go    = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_ISSUE: lcg_go = 1'b1;
            ST_WAIT:  mem_we = lcg_rsp.done && (pass_reg == PASS_FILL);
            ST_READ:  mem_re = 1'b1;
            ST_WRITE: begin
                mem_we    = 1'b1;
                div_start = 1'b1;
            end
            ST_OUT:   out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_comb begin
        if (pass_reg == PASS_FILL) begin
            mem_waddr = fill_reg;
            mem_wdata = {lcg_rsp.val[LANE_MINOR], lcg_rsp.val[LANE_MAJOR]};
        end else begin
            mem_waddr = slot_reg;
            mem_wdata = {gen_minor_reg, gen_major_reg};
        end
    end

    assign div_req.start = div_start;
    assign div_req.major = rd_data_reg[GEN_W-1:0];
    assign div_req.minor = rd_data_reg[2*GEN_W-1:GEN_W];

    // Shuffle table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pass_reg       <= PASS_SEED;
            gen_major_reg  <= '0;
            gen_minor_reg  <= '0;
            gen_select_reg <= '0;
            seeded_reg     <= 1'b0;
            fill_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            if (state_reg == ST_WAIT && lcg_rsp.done) begin
                case (pass_reg)
                    PASS_SEED, PASS_MIX1: begin
                        gen_major_reg <= lcg_rsp.val[LANE_MAJOR];
                    end
                    PASS_MIX2: begin
                        gen_major_reg <= lcg_rsp.val[LANE_MAJOR];
                        gen_minor_reg <= lcg_rsp.val[LANE_MINOR];
                        fill_reg      <= '0;
                    end
                    PASS_FILL: begin
                        gen_major_reg <= lcg_rsp.val[LANE_MAJOR];
                        gen_minor_reg <= lcg_rsp.val[LANE_MINOR];
                        // select comes from the major value seen before the first fill step
                        if (fill_reg == '0) begin
                            gen_select_reg <= lcg_rsp.val[LANE_SELECT];
                        end
                        if (fill_reg == LAST_IDX) begin
                            seeded_reg <= 1'b1;
                        end
                        fill_reg <= fill_reg + 1'b1;
                    end
                    PASS_DRAW: begin
                        gen_major_reg  <= lcg_rsp.val[LANE_MAJOR];
                        gen_minor_reg  <= lcg_rsp.val[LANE_MINOR];
                        gen_select_reg <= lcg_rsp.val[LANE_SELECT];
                    end
                    default: ;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seed_reg <= s_tdata;
        end
        if (state_reg == ST_WAIT && lcg_rsp.done && pass_reg == PASS_DRAW) begin
            slot_reg <= slot_calc;
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0, div_rsp.fraction, rd_data_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_lcg_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        lcg_rsp.done |-> state_reg == ST_WAIT)
        else $error("reduction result arrived outside its wait state");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_draw_after_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> seeded_reg)
        else $error("table read before the table was filled");

    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> mem_waddr <= LAST_IDX)
        else $error("table write beyond last slot");

endmodule

// ===== verif/shuffled_triple_lcg_uniform_rng_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_triple_lcg_uniform_rng_unit_test - stream-level check of the RNG
// Sends signed seed items and compares each returned deviate item (table
// pair and Q0.24 fraction) with a cycle-free model of the three generators
// and the shuffle table. Traffic runs in three phases of sender and
// receiver idling, with occasional negative seeds to force table refills.
// ----------------------------------------------------------------------------
module shuffled_triple_lcg_uniform_rng_unit_test;

    localparam int TABLE_DEPTH = 97;

    localparam longint unsigned MAJOR_MOD  = 259200;
    localparam longint unsigned MAJOR_MUL  = 7141;
    localparam longint unsigned MAJOR_INC  = 54773;
    localparam longint unsigned MINOR_MOD  = 134456;
    localparam longint unsigned MINOR_MUL  = 8121;
    localparam longint unsigned MINOR_INC  = 28411;
    localparam longint unsigned SELECT_MOD = 243000;
    localparam longint unsigned SELECT_MUL = 4561;
    localparam longint unsigned SELECT_INC = 51349;

    localparam int SEED_MAX       = 54773;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int ITEMS_PER_PASS = 577;

    typedef struct packed {
        logic [23:0] fraction;
        logic [17:0] minor_part;
        logic [17:0] major_part;
    } deviate_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // seed[31:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // major_part[17:0], minor_part[35:18],
                                   // fraction[59:36], zero[63:60]

    // Generator and table state of the model
    logic [17:0] major_gen;
    logic [17:0] minor_gen;
    logic [17:0] select_gen;
    logic [17:0] major_slot [TABLE_DEPTH];
    logic [17:0] minor_slot [TABLE_DEPTH];
    bit          table_seeded;

    logic [31:0] pending_seeds [$];
    deviate_t    expected_deviates [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int items_sent;
    int deviates_checked;
    int refill_count;
    int stall_cycles;

    shuffled_triple_lcg_uniform_rng_unit #(
        .TABLE_SIZE(TABLE_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [17:0] step_lcg(input logic [17:0] x,
                                             input longint unsigned mul,
                                             input longint unsigned inc,
                                             input longint unsigned modulus);
        longint unsigned wide_x;
        wide_x = x;
        return 18'((wide_x * mul + inc) % modulus);
    endfunction

    function automatic void refill_table(input longint seed_val);
        longint start;
        start = (longint'(MAJOR_INC) - seed_val) % longint'(MAJOR_MOD);
        if (start < 0) begin
            start += longint'(MAJOR_MOD);
        end
        major_gen  = 18'(start);
        major_gen  = step_lcg(major_gen, MAJOR_MUL, MAJOR_INC, MAJOR_MOD);
        minor_gen  = 18'(major_gen % 18'(MINOR_MOD));
        major_gen  = step_lcg(major_gen, MAJOR_MUL, MAJOR_INC, MAJOR_MOD);
        select_gen = 18'(major_gen % 18'(SELECT_MOD));
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            major_gen     = step_lcg(major_gen, MAJOR_MUL, MAJOR_INC, MAJOR_MOD);
            minor_gen     = step_lcg(minor_gen, MINOR_MUL, MINOR_INC, MINOR_MOD);
            major_slot[k] = major_gen;
            minor_slot[k] = minor_gen;
        end
        table_seeded = 1'b1;
        refill_count++;
    endfunction

    // Advance the model by one request and return the deviate it yields
    function automatic deviate_t draw_deviate(input logic [31:0] seed_bits);
        longint          seed_val;
        longint unsigned slot;
        longint unsigned num;
        deviate_t        d;
        seed_val = $signed(seed_bits);
        if (seed_val < 0 || !table_seeded) begin
            refill_table(seed_val);
        end
        major_gen  = step_lcg(major_gen, MAJOR_MUL, MAJOR_INC, MAJOR_MOD);
        minor_gen  = step_lcg(minor_gen, MINOR_MUL, MINOR_INC, MINOR_MOD);
        select_gen = step_lcg(select_gen, SELECT_MUL, SELECT_INC, SELECT_MOD);
        slot = (longint'(TABLE_DEPTH) * select_gen) / SELECT_MOD;
        if (slot >= TABLE_DEPTH) begin
            slot = TABLE_DEPTH - 1;
        end
        d.major_part     = major_slot[slot];
        d.minor_part     = minor_slot[slot];
        major_slot[slot] = major_gen;
        minor_slot[slot] = minor_gen;
        num = longint'(d.major_part) * MINOR_MOD + d.minor_part;
        d.fraction = 24'((num << 24) / (MAJOR_MOD * MINOR_MOD));
        return d;
    endfunction

    function automatic logic [31:0] random_seed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            return {1'b1, 31'($urandom())};
        end else if (pick < 6) begin
            return -32'($urandom_range(64, 1));
        end else if (pick < 8) begin
            return 32'($urandom_range(SEED_MAX, SEED_MAX - 15));
        end else if (pick < 10) begin
            return 32'($urandom_range(15));
        end
        return 32'($urandom_range(SEED_MAX));
    endfunction

    // Sender: hold the item until taken, then predict it
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_deviates.push_back(draw_deviate(s_tdata));
                items_sent++;
            end
            if (pending_seeds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_seeds.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: compare each taken item with the oldest prediction
    always @(posedge aclk) begin
        deviate_t got;
        deviate_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = deviate_t'(m_tdata[59:0]);
                if (expected_deviates.size() == 0) begin
                    $error("deviate item with no request pending: %h", m_tdata);
                    error_count++;
                end else begin
                    want = expected_deviates.pop_front();
                    if (got.major_part !== want.major_part) begin
                        $error("major_part: expected %0d, got %0d",
                               want.major_part, got.major_part);
                        error_count++;
                    end
                    if (got.minor_part !== want.minor_part) begin
                        $error("minor_part: expected %0d, got %0d",
                               want.minor_part, got.minor_part);
                        error_count++;
                    end
                    if (got.fraction !== want.fraction) begin
                        $error("fraction: expected %0d, got %0d",
                               want.fraction, got.fraction);
                        error_count++;
                    end
                end
                deviates_checked++;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stop the run when neither side moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", stall_cycles);
            $display("[shuffled_triple_lcg_uniform_rng_unit] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        table_seeded  = 1'b0;
        major_gen     = '0;
        minor_gen     = '0;
        select_gen    = '0;
        error_count   = 0;
        items_sent    = 0;
        deviates_checked = 0;
        refill_count  = 0;
        send_idle_pct = 22;
        recv_idle_pct = 77;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // First request seeds the table even though the seed is not negative
        pending_seeds.push_back(32'(SEED_MAX));
        pending_seeds.push_back(32'd0);
        pending_seeds.push_back(32'd1);
        pending_seeds.push_back(32'(SEED_MAX - 1));
        pending_seeds.push_back(32'(SEED_MAX));
        pending_seeds.push_back(32'hFFFF_FFFF);
        pending_seeds.push_back(32'd5);
        pending_seeds.push_back(32'hFFFF_FFFF);
        pending_seeds.push_back(32'h8000_0000);
        pending_seeds.push_back(32'd12345);
        pending_seeds.push_back(32'hAAAA_AAAA);
        pending_seeds.push_back(32'hD555_5555);
        pending_seeds.push_back(32'h8000_0001);
        pending_seeds.push_back(-32'(SEED_MAX));
        pending_seeds.push_back(32'hFFFF_0000);
        pending_seeds.push_back(32'h0000_8000);
        pending_seeds.push_back(32'h0000_7FFF);
        for (int i = 0; i < 6; i++) begin
            pending_seeds.push_back(32'($urandom_range(SEED_MAX)));
        end

        for (int pass = 0; pass < 3; pass++) begin
            send_idle_pct = (pass == 0) ? 22 : (pass == 1) ? 77 : 0;
            recv_idle_pct = (pass == 0) ? 77 : (pass == 1) ? 22 : 0;
            for (int i = 0; i < ITEMS_PER_PASS; i++) begin
                pending_seeds.push_back(random_seed());
            end
            while (pending_seeds.size() > 0) @(negedge aclk);
        end

        while (s_tvalid || expected_deviates.size() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (expected_deviates.size() > 0) begin
            $error("%0d deviate items never arrived", expected_deviates.size());
            error_count++;
        end
        $display("sent %0d seed items, %0d of them forced a table refill",
                 items_sent, refill_count);
        $display("checked %0d deviate items over three idling patterns, %0d mismatches",
                 deviates_checked, error_count);
        if (error_count == 0) begin
            $display("[shuffled_triple_lcg_uniform_rng_unit] OK");
        end else begin
            $display("[shuffled_triple_lcg_uniform_rng_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/strng_pkg.sv
src/strng_lcg3.sv
src/strng_frac_div.sv
src/shuffled_triple_lcg_uniform_rng_unit.sv
verif/shuffled_triple_lcg_uniform_rng_unit_test.sv
